// ----- design/drw_pkg.sv -----
// ----------------------------------------------------------------------------
// drw_pkg
// Shared item types and codes for the datagram replay window filter.
// ----------------------------------------------------------------------------
package drw_pkg;

   // field widths fixed by the item format
   localparam int NUM_W     = 31;
   localparam int TIME_W    = 32;
   localparam int TIMEOUT_W = 20;
   localparam int COUNT_W   = 7;
   localparam int SPAN_W    = 7;

   // idle timeout after reset, in ms
   localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 20'd5000;

   // request kinds
   localparam logic REQ_RECEIVE = 1'b0;
   localparam logic REQ_RELEASE = 1'b1;

   // verdict codes
   localparam logic [1:0] VERDICT_ACCEPT  = 2'd0;
   localparam logic [1:0] VERDICT_DUP     = 2'd1;
   localparam logic [1:0] VERDICT_STALE   = 2'd2;
   localparam logic [1:0] VERDICT_RELEASE = 2'd3;

   // input item
   typedef struct packed {
      logic              req_type;
      logic [NUM_W-1:0]  seq_num;
      logic [TIME_W-1:0] timestamp_ms;
   } req_item_type;

   // result item
   typedef struct packed {
      logic [1:0]         verdict;
      logic               window_reset;
      logic [COUNT_W-1:0] received_count;
      logic [SPAN_W-1:0]  span;
   } rsp_item_type;

   // decision stage status handed to the count stage
   typedef struct packed {
      logic [1:0]        verdict;
      logic              window_reset;
      logic [SPAN_W-1:0] span;
   } dec_info_type;

endpackage

// ----- design/drw_window_core.sv -----
// ----------------------------------------------------------------------------
// drw_window_core
// Window state and per-item decision: timeout clear, window advance, bit test
// and set, floor update and span. Result is registered for the count stage.
// ----------------------------------------------------------------------------
module drw_window_core #(
   parameter int WINDOW_BITS = 64
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_wr_en,
   input  logic [drw_pkg::TIMEOUT_W-1:0]   csr_wr_data,
   input  logic                            item_valid,
   output logic                            item_ready,
   input  drw_pkg::req_item_type           item,
   output logic                            dec_valid,
   input  logic                            dec_ready,
   output drw_pkg::dec_info_type           dec_info,
   output logic [WINDOW_BITS-1:0]          dec_mask
);
   import drw_pkg::*;

   localparam int IW = $clog2(WINDOW_BITS);
   localparam logic signed [32:0] WIN_S = 33'(WINDOW_BITS);
   localparam logic signed [32:0] ONE_S = 33'sd1;

   // window state
   logic [WINDOW_BITS-1:0] mask_ff, mask_in;
   logic signed [31:0]     highest_ff, highest_in;
   logic signed [31:0]     first_ff, first_in;
   logic signed [31:0]     floor_ff, floor_in;
   logic [TIME_W-1:0]      last_time_ff, last_time_in;
   logic [TIMEOUT_W-1:0]   timeout_ff;

   // decision register
   logic                   dec_valid_ff;
   dec_info_type           dec_info_ff, dec_info_in;
   logic [WINDOW_BITS-1:0] dec_mask_ff;

   logic                   fire;
   logic [TIME_W-1:0]      elapsed;
   logic                   timeout_hit;
   logic [WINDOW_BITS-1:0] eff_mask;
   logic signed [31:0]     eff_high, eff_first, eff_floor;
   logic [TIME_W-1:0]      eff_last;
   logic signed [31:0]     num_s;
   logic signed [32:0]     num_ext, hi_ext, adv_d, pos_d, span_d;
   logic                   above_floor, in_win, advance, big, eligible, hit;
   logic [WINDOW_BITS-1:0] mask_mid, mask_set;
   logic signed [31:0]     high_mid;
   logic [IW-1:0]          pos;

   assign item_ready = !dec_valid_ff || dec_ready;
   assign fire       = item_valid && item_ready;

   // idle timeout test, then the state as seen after a possible clear
   always_comb begin
      elapsed     = item.timestamp_ms - last_time_ff;
      timeout_hit = (item.req_type == REQ_RECEIVE) && (elapsed > TIME_W'(timeout_ff));
      eff_mask    = timeout_hit ? '0 : mask_ff;
      eff_high    = timeout_hit ? -32'sd1 : highest_ff;
      eff_first   = timeout_hit ? -32'sd1 : first_ff;
      eff_floor   = timeout_hit ? -32'sd1 : floor_ff;
      eff_last    = timeout_hit ? '0 : last_time_ff;
   end

   // window position of the packet number
   always_comb begin
      num_s       = signed'({1'b0, item.seq_num});
      num_ext     = signed'({2'b00, item.seq_num});
      hi_ext      = {eff_high[31], eff_high};
      above_floor = num_s > eff_floor;
      in_win      = (num_ext + WIN_S) > hi_ext;
      eligible    = above_floor && in_win;
      advance     = num_ext > hi_ext;
      adv_d       = num_ext - hi_ext;
      big         = adv_d >= WIN_S;
      if (!advance) begin
         mask_mid = eff_mask;
      end else if (big) begin
         mask_mid = '0;
      end else begin
         mask_mid = eff_mask << adv_d[IW-1:0];
      end
      high_mid = advance ? num_s : eff_high;
      pos_d    = {high_mid[31], high_mid} - num_ext;
      pos      = pos_d[IW-1:0];
      hit      = mask_mid[pos];
      mask_set = mask_mid;
      mask_set[pos] = 1'b1;
   end

   // next state and verdict
   always_comb begin
      mask_in      = mask_ff;
      highest_in   = highest_ff;
      first_in     = first_ff;
      floor_in     = floor_ff;
      last_time_in = last_time_ff;
      dec_info_in  = '0;
      if (item.req_type == REQ_RELEASE) begin
         floor_in            = num_s;
         dec_info_in.verdict = VERDICT_RELEASE;
      end else begin
         mask_in                  = eff_mask;
         highest_in               = eff_high;
         first_in                 = eff_first;
         floor_in                 = eff_floor;
         last_time_in             = eff_last;
         dec_info_in.window_reset = timeout_hit;
         if (!eligible) begin
            dec_info_in.verdict = VERDICT_STALE;
         end else if (hit) begin
            mask_in             = mask_mid;
            highest_in          = high_mid;
            dec_info_in.verdict = VERDICT_DUP;
         end else begin
            mask_in             = mask_set;
            highest_in          = high_mid;
            last_time_in        = item.timestamp_ms;
            if (eff_first[31]) begin
               first_in = num_s;
            end
            dec_info_in.verdict = VERDICT_ACCEPT;
         end
      end
      // span clamped to one window
      span_d = {highest_in[31], highest_in} - {first_in[31], first_in} + ONE_S;
      if (span_d >= WIN_S) begin
         dec_info_in.span = SPAN_W'(WINDOW_BITS);
      end else if (span_d < ONE_S) begin
         dec_info_in.span = SPAN_W'(1);
      end else begin
         dec_info_in.span = span_d[SPAN_W-1:0];
      end
   end

   // state and configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff      <= '0;
         highest_ff   <= -32'sd1;
         first_ff     <= -32'sd1;
         floor_ff     <= -32'sd1;
         last_time_ff <= '0;
         timeout_ff   <= TIMEOUT_RESET;
      end else begin
         if (fire) begin
            mask_ff      <= mask_in;
            highest_ff   <= highest_in;
            first_ff     <= first_in;
            floor_ff     <= floor_in;
            last_time_ff <= last_time_in;
         end
         if (csr_wr_en) begin
            timeout_ff <= csr_wr_data;
         end
      end
   end

   // decision register
   always_ff @(posedge clock) begin
      if (reset) begin
         dec_valid_ff <= 1'b0;
      end else if (item_ready) begin
         dec_valid_ff <= item_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         dec_info_ff <= dec_info_in;
         dec_mask_ff <= mask_in;
      end
   end

   assign dec_valid = dec_valid_ff;
   assign dec_info  = dec_info_ff;
   assign dec_mask  = dec_mask_ff;

endmodule

// ----- design/drw_popcount.sv -----
// ----------------------------------------------------------------------------
// drw_popcount
// Two-stage bit count of the window bitmap: byte counts, then their sum into
// the result register.
// ----------------------------------------------------------------------------
module drw_popcount #(
   parameter int WINDOW_BITS = 64
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   output logic                    in_ready,
   input  drw_pkg::dec_info_type   in_info,
   input  logic [WINDOW_BITS-1:0]  in_mask,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output drw_pkg::rsp_item_type   rsp_item
);
   import drw_pkg::*;

   localparam int NGRP = (WINDOW_BITS + 7) / 8;
   localparam int PADW = NGRP * 8;

   logic [PADW-1:0]    pad;
   logic [3:0]         part_in [NGRP];
   logic [3:0]         part_ff [NGRP];
   dec_info_type       info_ff;
   logic               part_valid_ff;
   logic               part_ready;
   logic [COUNT_W-1:0] total;
   logic               rsp_valid_ff;
   rsp_item_type       rsp_item_ff;

   assign part_ready = !rsp_valid_ff || rsp_ready;
   assign in_ready   = !part_valid_ff || part_ready;

   // per-byte counts
   always_comb begin
      pad = PADW'(in_mask);
      for (int g = 0; g < NGRP; g++) begin
         part_in[g] = '0;
         for (int b = 0; b < 8; b++) begin
            part_in[g] = part_in[g] + 4'(pad[g*8+b]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         part_valid_ff <= 1'b0;
      end else if (in_ready) begin
         part_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         part_ff <= part_in;
         info_ff <= in_info;
      end
   end

   // sum of byte counts
   always_comb begin
      total = '0;
      for (int g = 0; g < NGRP; g++) begin
         total = total + COUNT_W'(part_ff[g]);
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (part_ready) begin
         rsp_valid_ff <= part_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (part_valid_ff && part_ready) begin
         rsp_item_ff.verdict        <= info_ff.verdict;
         rsp_item_ff.window_reset   <= info_ff.window_reset;
         rsp_item_ff.received_count <= total;
         rsp_item_ff.span           <= info_ff.span;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

endmodule

// ----- design/datagram_replay_window.sv -----
// ----------------------------------------------------------------------------
// datagram_replay_window
// Anti-replay filter for one packet stream with a sliding window bitmap.
// req_ channel: receive items (sequence number, ms timestamp) and release
// items (number handed to the consumer, which becomes the floor).
// rsp_ channel: one result per item with verdict, timeout flag, bitmap
// population count and span. csr_ port sets the idle timeout in ms.
// Throughput: one item per cycle while rsp_ready does not stall; the decision stage
// reads and rewrites the window state for each item, which is what sets that rate.
// An accepted item passes the input register, decision register, byte-count
// register and result register, in that order, before rsp_valid rises.
// Reset clears the window, sets the floor and numbers to minus one and the
// timeout to 5000 ms; no item is pending afterwards.
// A stalled rsp_ready holds the result; four items, one per register, stay
// buffered in the pipeline before req_ready drops.
// ----------------------------------------------------------------------------
module datagram_replay_window #(
   parameter int WINDOW_BITS = 64
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_wr_en,
   input  logic [drw_pkg::TIMEOUT_W-1:0] csr_wr_data,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  drw_pkg::req_item_type         req_item,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output drw_pkg::rsp_item_type         rsp_item
);
   import drw_pkg::*;

   logic                   in_valid_ff;
   req_item_type           in_item_ff;
   logic                   core_ready;
   logic                   dec_valid;
   logic                   dec_ready;
   dec_info_type           dec_info;
   logic [WINDOW_BITS-1:0] dec_mask;

   assign req_ready = !in_valid_ff || core_ready;

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_item_ff <= req_item;
      end
   end

   drw_window_core #(
      .WINDOW_BITS (WINDOW_BITS)
   ) u_core (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .item_valid  (in_valid_ff),
      .item_ready  (core_ready),
      .item        (in_item_ff),
      .dec_valid   (dec_valid),
      .dec_ready   (dec_ready),
      .dec_info    (dec_info),
      .dec_mask    (dec_mask)
   );

   drw_popcount #(
      .WINDOW_BITS (WINDOW_BITS)
   ) u_count (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (dec_valid),
      .in_ready  (dec_ready),
      .in_info   (dec_info),
      .in_mask   (dec_mask),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_item  (rsp_item)
   );

`ifndef SYNTHESIS
   // a release never reports a timeout clear
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_item.verdict == VERDICT_RELEASE) |-> !rsp_item.window_reset)
      else $error("release item reports window reset");

   // an accepted packet leaves at least its own bit set
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_item.verdict == VERDICT_ACCEPT) |-> (rsp_item.received_count != '0))
      else $error("accepted item with empty window");

   // count and span stay within one window
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_item.received_count <= COUNT_W'(WINDOW_BITS)
                     && rsp_item.span >= SPAN_W'(1)
                     && rsp_item.span <= SPAN_W'(WINDOW_BITS)))
      else $error("count or span out of range");
`endif

endmodule
